[rtl/mlp_pkg.sv]
// Shared types, constants and arithmetic helpers for the two-layer perceptron.
// Holds the sigmoid ROM, built at elaboration. No dependencies.
package mlp_pkg;

	// Network shape
	localparam int IN_UNITS    = 8;
	localparam int HID_UNITS   = 12;
	localparam int SIG_DEPTH   = 256;

	localparam int IN_W      = (IN_UNITS > 1) ? $clog2(IN_UNITS) : 1;
	localparam int HID_W     = (HID_UNITS > 1) ? $clog2(HID_UNITS) : 1;
	localparam int SIG_IDX_W = $clog2(SIG_DEPTH);

	// Weight store layout
	localparam int OFS_BH      = IN_UNITS * HID_UNITS;
	localparam int OFS_WHO     = OFS_BH + HID_UNITS;
	localparam int OFS_BO      = OFS_WHO + HID_UNITS;

	// Datapath widths
	localparam int PROD_W = 33;                           // 17s x 16s
	localparam int HSUM_W = PROD_W + $clog2(IN_UNITS);
	localparam int OSUM_W = PROD_W + $clog2(HID_UNITS);
	localparam int STEP_W = 31;                           // lr * hidden delta
	localparam int UPD_W  = STEP_W + 17;                  // step * feature

	localparam logic [15:0] ACT_HALF = 16'd16384;
	localparam logic [15:0] LR_RESET = 16'd655;

	// Action codes
	localparam logic [1:0] ACT_LOAD     = 2'd0;
	localparam logic [1:0] ACT_CLASSIFY = 2'd1;
	localparam logic [1:0] ACT_TRAIN    = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [6:0]         weight_index;
		logic signed [15:0] weight_value;
		logic [15:0]        feature_a;
		logic [15:0]        feature_b;
		logic [15:0]        feature_c;
		logic [15:0]        feature_d;
		logic [15:0]        feature_e;
		logic [15:0]        feature_f;
		logic [15:0]        feature_g;
		logic [15:0]        feature_h;
		logic               true_label;
	} item_t;

	typedef struct packed {
		logic        predicted_class;
		logic [15:0] output_score;
		logic [15:0] squared_error;
	} result_t;

	// Controls from the sequencer to one lane
	typedef struct packed {
		logic             load_en;
		logic [HID_W-1:0] load_idx;
		logic [HID_W-1:0] fwd_idx;
		logic             upd_wr;
		logic [HID_W-1:0] upd_idx;
	} lane_ctrl_t;

	// Decoded weight store address
	typedef struct packed {
		logic             is_lane;
		logic             is_bh;
		logic             is_who;
		logic             is_bo;
		logic [IN_W-1:0]  lane;
		logic [HID_W-1:0] unit;
	} store_sel_t;

	typedef logic [15:0] sig_rom_t [SIG_DEPTH];

	// Unsigned shift-and-subtract quotient (elaboration only)
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sigmoid of a non-negative Q.16 value, Q0.15 (elaboration only)
	function automatic logic [15:0] sig_pos(input longint unsigned xq16);
		longint unsigned y;
		longint unsigned term;
		longint unsigned t;
		longint unsigned d;
		longint          acc;
		y    = xq16 << 11;
		term = 64'd1 << 31;
		acc  = longint'(term);
		for (int n = 1; n <= 12; n++) begin
			term = udiv64((term * y) >> 31, 64'(n));
			if ((n & 1) == 1) acc = acc - longint'(term);
			else acc = acc + longint'(term);
		end
		t = (acc > 0) ? longint'(acc) : 64'd0;
		for (int k = 0; k < 4; k++) t = (t * t) >> 31;
		d = (64'd1 << 31) + t;
		return 16'(udiv64((64'd1 << 46) + (d >> 1), d));
	endfunction

	function automatic sig_rom_t build_sig_rom();
		sig_rom_t rom;
		longint   m;
		for (int k = 0; k < SIG_DEPTH; k++) begin
			m = -64'sd524288 + (longint'(2 * k + 1) * 64'sd524288) / SIG_DEPTH;
			if (m >= 0) rom[k] = sig_pos(m);
			else rom[k] = 16'd32768 - sig_pos(-m);
		end
		return rom;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sig_rom();

	// ROM lookup on a clamped Q3.12 pre-activation
	function automatic logic [15:0] sig_lookup(input logic signed [15:0] x);
		logic [15:0]             off;
		logic [16+SIG_IDX_W-1:0] sc;
		off = {~x[15], x[14:0]};
		sc  = (16 + SIG_IDX_W)'(off) * (16 + SIG_IDX_W)'(SIG_DEPTH);
		return SIG_ROM[sc[16+SIG_IDX_W-1:16]];
	endfunction

	function automatic logic signed [15:0] clamp16(input logic signed [31:0] v);
		if (v > 32'sd32767) return 16'sh7fff;
		if (v < -32'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767) return 16'sh7fff;
		if (v < -20'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// Round to nearest, ties up, then arithmetic shift right
	function automatic logic signed [19:0] round_shr(input logic signed [49:0] v, input int s);
		logic signed [49:0] r;
		r = (v + (50'sd1 <<< (s - 1))) >>> s;
		return r[19:0];
	endfunction

	// Slope of sigmoid from activation: a*(1-a)
	function automatic logic [13:0] slope(input logic [15:0] a);
		logic [31:0] p;
		p = 32'(a) * (32'd32768 - 32'(a));
		return p[28:15];
	endfunction

	// Split a store address into lane weight, hidden bias, output weight or bias
	function automatic store_sel_t store_decode(input logic [6:0] idx);
		store_sel_t  s;
		int unsigned v;
		int unsigned j;
		s = '0;
		v = 32'(idx);
		j = 0;
		if (v < OFS_BH) begin
			for (int k = 1; k < IN_UNITS; k++) if (v >= k * HID_UNITS) j = k;
			s.is_lane = 1'b1;
			s.lane    = IN_W'(j);
			s.unit    = HID_W'(v - j * HID_UNITS);
		end else if (v < OFS_WHO) begin
			s.is_bh = 1'b1;
			s.unit  = HID_W'(v - OFS_BH);
		end else if (v < OFS_BO) begin
			s.is_who = 1'b1;
			s.unit   = HID_W'(v - OFS_WHO);
		end else if (v == OFS_BO) begin
			s.is_bo = 1'b1;
		end
		return s;
	endfunction

endpackage

[rtl/mlp_lane.sv]
// One input lane: the weights from one feature to every hidden unit, with the
// forward product and the gradient update for that feature. Uses mlp_pkg.
module mlp_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mlp_pkg::lane_ctrl_t                ctrl,
	input  logic signed [15:0]                 load_value,
	input  logic [15:0]                        feature,
	input  logic signed [mlp_pkg::STEP_W-1:0]  step,
	output logic signed [mlp_pkg::PROD_W-1:0]  prod_s1
);
	import mlp_pkg::*;

	logic signed [15:0]      w_q [HID_UNITS];
	logic signed [UPD_W-1:0] upd_s4;
	logic signed [19:0]      upd_sum;

	// Updated weight for the unit being written back
	assign upd_sum = 20'(w_q[ctrl.upd_idx]) + round_shr(50'(upd_s4), 34);

	// Weight bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HID_UNITS; i++) w_q[i] <= '0;
		end else if (ctrl.load_en) begin
			w_q[ctrl.load_idx] <= load_value;
		end else if (ctrl.upd_wr) begin
			w_q[ctrl.upd_idx] <= sat16(upd_sum);
		end
	end

	// Forward product and update product
	always_ff @(posedge clk) begin
		prod_s1 <= $signed({1'b0, feature}) * w_q[ctrl.fwd_idx];
		upd_s4  <= step * $signed({1'b0, feature});
	end

endmodule

[rtl/mlp_merge.sv]
// Merging stage: adds the lane products, applies the hidden bias and looks up
// the sigmoid. Uses mlp_pkg.
module mlp_merge (
	input  logic                              clk,
	input  logic signed [mlp_pkg::PROD_W-1:0] prod [mlp_pkg::IN_UNITS],
	input  logic signed [15:0]                bias,
	output logic [15:0]                       act_s3
);
	import mlp_pkg::*;

	logic signed [HSUM_W-1:0] tree_sum;
	logic signed [HSUM_W-1:0] sum_s2;
	logic signed [15:0]       pre_act;

	// Sum over lanes
	always_comb begin
		tree_sum = '0;
		for (int j = 0; j < IN_UNITS; j++) tree_sum = tree_sum + HSUM_W'(prod[j]);
	end

	// Floor to Q3.12, add bias, clamp
	assign pre_act = clamp16(32'(sum_s2 >>> 15) + 32'(bias));

	always_ff @(posedge clk) begin
		sum_s2 <= tree_sum;
		act_s3 <= sig_lookup(pre_act);
	end

endmodule

[rtl/mlp_sgd_train_and_infer.sv]
// Top level of the 8-12-1 sigmoid perceptron with weight store and SGD step.
// Uses mlp_pkg, mlp_lane and mlp_merge.
//
// One item at a time: busy rises after start is taken and falls in the cycle
// that result_strobe shows the result, which must be captured there since the
// receiver cannot stall. The length of a classification or a training item is
// set by the hidden units, which go one per cycle through the eight feature
// lanes and then through the shared output multiply-accumulate, and in
// training once more through the delta and update pipeline.
module mlp_sgd_train_and_infer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  mlp_pkg::item_t   item,
	output logic             busy,
	output logic             result_strobe,
	output mlp_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [15:0]      cfg_data
);
	import mlp_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_FWD   = 4'd2;
	localparam logic [3:0] ST_OUT   = 4'd3;
	localparam logic [3:0] ST_ERR   = 4'd4;
	localparam logic [3:0] ST_DELTA = 4'd5;
	localparam logic [3:0] ST_STEP  = 4'd6;
	localparam logic [3:0] ST_BIAS  = 4'd7;
	localparam logic [3:0] ST_TRAIN = 4'd8;

	localparam logic [HID_W-1:0] LAST_UNIT = HID_W'(HID_UNITS - 1);

	// Control
	logic [3:0]       state_q;
	logic [HID_W-1:0] iss_q;
	logic             issuing_q;
	logic             fwd_v_s1, fwd_v_s2, fwd_v_s3, fwd_v_s4;
	logic             trn_v_s1, trn_v_s2, trn_v_s3, trn_v_s4;
	logic [15:0]      lr_q;
	logic             strobe_q;
	result_t          result_q;

	// Weights outside the lanes
	logic signed [15:0] bh_q  [HID_UNITS];
	logic signed [15:0] who_q [HID_UNITS];
	logic signed [15:0] bo_q;

	// Payload
	item_t              item_q;
	logic [15:0]        ah_q [HID_UNITS];
	logic [HID_W-1:0]   fwd_idx_s1, fwd_idx_s2, fwd_idx_s3, fwd_idx_s4;
	logic [HID_W-1:0]   trn_idx_s1, trn_idx_s2, trn_idx_s3, trn_idx_s4;
	logic signed [PROD_W-1:0] omul_s4;
	logic signed [OSUM_W-1:0] oacc_q;
	logic [15:0]        score_q;
	logic               cls_q;
	logic [15:0]        sqerr_q;
	logic [13:0]        slope_o_q;
	logic signed [14:0] d_o_q;
	logic signed [31:0] p_o_q;
	logic signed [30:0] trn_m1_s1;
	logic [13:0]        trn_slope_s1;
	logic signed [48:0] trn_q_s1;
	logic signed [15:0] trn_dh_s2;
	logic signed [STEP_W-1:0] trn_ph_s3;

	// Combinational
	store_sel_t         sel;
	logic [15:0]        feat [IN_UNITS];
	lane_ctrl_t         lane_ctrl [IN_UNITS];
	logic signed [PROD_W-1:0] lane_prod [IN_UNITS];
	logic [15:0]        act_s3;
	logic [15:0]        score_c;
	logic signed [16:0] err_c;
	logic signed [33:0] err_sq_c;
	logic signed [30:0] dh_shift_c;
	logic signed [45:0] dh_full_c;
	logic signed [32:0] ph_full_c;
	logic               accept;

	assign accept        = start && (state_q == ST_IDLE);
	assign busy          = (state_q != ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign result_strobe = strobe_q;
	assign result        = result_q;

	assign sel = store_decode(item_q.weight_index);

	// Feature fields to lanes
	always_comb begin
		for (int j = 0; j < IN_UNITS; j++) begin
			unique case (j)
				0:       feat[j] = item_q.feature_a;
				1:       feat[j] = item_q.feature_b;
				2:       feat[j] = item_q.feature_c;
				3:       feat[j] = item_q.feature_d;
				4:       feat[j] = item_q.feature_e;
				5:       feat[j] = item_q.feature_f;
				6:       feat[j] = item_q.feature_g;
				7:       feat[j] = item_q.feature_h;
				default: feat[j] = '0;
			endcase
		end
	end

	// Lane controls
	always_comb begin
		for (int j = 0; j < IN_UNITS; j++) begin
			lane_ctrl[j].load_en  = (state_q == ST_LOAD) && sel.is_lane &&
				(sel.lane == IN_W'(j));
			lane_ctrl[j].load_idx = sel.unit;
			lane_ctrl[j].fwd_idx  = iss_q;
			lane_ctrl[j].upd_wr   = trn_v_s4;
			lane_ctrl[j].upd_idx  = trn_idx_s4;
		end
	end

	for (genvar j = 0; j < IN_UNITS; j++) begin : g_lane
		mlp_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (lane_ctrl[j]),
			.load_value (item_q.weight_value),
			.feature    (feat[j]),
			.step       (trn_ph_s3),
			.prod_s1    (lane_prod[j])
		);
	end

	mlp_merge u_merge (
		.clk    (clk),
		.prod   (lane_prod),
		.bias   (bh_q[fwd_idx_s2]),
		.act_s3 (act_s3)
	);

	// Output unit, squared error and hidden delta arithmetic
	assign score_c    = sig_lookup(clamp16(32'(oacc_q >>> 15) + 32'(bo_q)));
	assign err_c      = item_q.true_label ? (17'sd32768 - $signed({1'b0, score_q}))
		: -$signed({1'b0, score_q});
	assign err_sq_c   = err_c * err_c;
	assign dh_shift_c = trn_m1_s1 >>> 12;
	assign dh_full_c  = (dh_shift_c * $signed({1'b0, trn_slope_s1})) >>> 15;
	assign ph_full_c  = $signed({1'b0, lr_q}) * trn_dh_s2;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			iss_q     <= '0;
			issuing_q <= 1'b0;
			fwd_v_s1  <= 1'b0;
			fwd_v_s2  <= 1'b0;
			fwd_v_s3  <= 1'b0;
			fwd_v_s4  <= 1'b0;
			trn_v_s1  <= 1'b0;
			trn_v_s2  <= 1'b0;
			trn_v_s3  <= 1'b0;
			trn_v_s4  <= 1'b0;
			lr_q      <= LR_RESET;
			strobe_q  <= 1'b0;
			result_q  <= '0;
		end else begin
			strobe_q <= 1'b0;
			fwd_v_s1 <= issuing_q && (state_q == ST_FWD);
			fwd_v_s2 <= fwd_v_s1;
			fwd_v_s3 <= fwd_v_s2;
			fwd_v_s4 <= fwd_v_s3;
			trn_v_s1 <= issuing_q && (state_q == ST_TRAIN);
			trn_v_s2 <= trn_v_s1;
			trn_v_s3 <= trn_v_s2;
			trn_v_s4 <= trn_v_s3;

			if (cfg_valid && cfg_ready) lr_q <= cfg_data;

			if (issuing_q && (state_q == ST_FWD || state_q == ST_TRAIN)) begin
				if (iss_q == LAST_UNIT) issuing_q <= 1'b0;
				else iss_q <= iss_q + 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						iss_q     <= '0;
						issuing_q <= (item.action != ACT_LOAD);
						state_q   <= (item.action == ACT_LOAD) ? ST_LOAD : ST_FWD;
					end
				end
				ST_LOAD: begin
					strobe_q <= 1'b1;
					result_q <= '0;
					state_q  <= ST_IDLE;
				end
				ST_FWD: begin
					if (fwd_v_s4 && fwd_idx_s4 == LAST_UNIT) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (item_q.action == ACT_TRAIN) begin
						state_q <= ST_ERR;
					end else begin
						strobe_q <= 1'b1;
						result_q <= '{predicted_class: score_c > ACT_HALF,
							output_score: score_c, squared_error: 16'd0};
						state_q  <= ST_IDLE;
					end
				end
				ST_ERR:   state_q <= ST_DELTA;
				ST_DELTA: state_q <= ST_STEP;
				ST_STEP:  state_q <= ST_BIAS;
				ST_BIAS: begin
					iss_q     <= '0;
					issuing_q <= 1'b1;
					state_q   <= ST_TRAIN;
				end
				ST_TRAIN: begin
					if (trn_v_s4 && trn_idx_s4 == LAST_UNIT) begin
						strobe_q <= 1'b1;
						result_q <= '{predicted_class: cls_q, output_score: score_q,
							squared_error: sqerr_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hidden biases, output weights and output bias
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HID_UNITS; i++) begin
				bh_q[i]  <= '0;
				who_q[i] <= '0;
			end
			bo_q <= '0;
		end else begin
			if (state_q == ST_LOAD) begin
				if (sel.is_bh) bh_q[sel.unit] <= item_q.weight_value;
				if (sel.is_who) who_q[sel.unit] <= item_q.weight_value;
				if (sel.is_bo) bo_q <= item_q.weight_value;
			end
			if (state_q == ST_BIAS) bo_q <= sat16(20'(bo_q) + round_shr(50'(p_o_q), 19));
			if (trn_v_s1)
				who_q[trn_idx_s1] <= sat16(20'(who_q[trn_idx_s1]) +
					round_shr(50'(trn_q_s1), 34));
			if (trn_v_s3)
				bh_q[trn_idx_s3] <= sat16(20'(bh_q[trn_idx_s3]) +
					round_shr(50'(trn_ph_s3), 19));
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			oacc_q <= '0;
		end

		// forward pipeline indices and output accumulation
		fwd_idx_s1 <= iss_q;
		fwd_idx_s2 <= fwd_idx_s1;
		fwd_idx_s3 <= fwd_idx_s2;
		fwd_idx_s4 <= fwd_idx_s3;
		if (fwd_v_s3) ah_q[fwd_idx_s3] <= act_s3;
		omul_s4 <= $signed({1'b0, act_s3}) * who_q[fwd_idx_s3];
		if (fwd_v_s4) oacc_q <= oacc_q + OSUM_W'(omul_s4);

		if (state_q == ST_OUT) begin
			score_q <= score_c;
			cls_q   <= (score_c > ACT_HALF);
		end
		if (state_q == ST_ERR) begin
			slope_o_q <= slope(score_q);
			sqerr_q   <= err_sq_c[30:15];
		end
		if (state_q == ST_DELTA) begin
			if (item_q.true_label && !cls_q) d_o_q <= $signed({1'b0, slope_o_q});
			else if (!item_q.true_label && cls_q) d_o_q <= -$signed({1'b0, slope_o_q});
			else d_o_q <= '0;
		end
		if (state_q == ST_STEP) p_o_q <= $signed({1'b0, lr_q}) * d_o_q;

		// training pipeline
		trn_idx_s1   <= iss_q;
		trn_idx_s2   <= trn_idx_s1;
		trn_idx_s3   <= trn_idx_s2;
		trn_idx_s4   <= trn_idx_s3;
		trn_m1_s1    <= d_o_q * who_q[iss_q];
		trn_slope_s1 <= slope(ah_q[iss_q]);
		trn_q_s1     <= p_o_q * $signed({1'b0, ah_q[iss_q]});
		trn_dh_s2    <= dh_full_c[15:0];
		trn_ph_s3    <= ph_full_c[STEP_W-1:0];
	end

endmodule

[rtl/mlp_checker.sv]
// Port-level checks on the perceptron top level, and the bind that attaches
// them. Uses mlp_pkg and mlp_sgd_train_and_infer.
module mlp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             result_strobe,
	input mlp_pkg::result_t result
);
	import mlp_pkg::*;

	// an accepted item keeps the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not raise busy");

	// the result goes out as busy drops
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !busy) else $error("result shown while busy");

	// one transfer per item, never two in a row
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe) else $error("repeated result transfer");

	// class agrees with the score threshold
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (result.predicted_class == (result.output_score > ACT_HALF)))
		else $error("class does not match score");

	// squared error stays within one
	a_sqerr: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (result.squared_error <= 16'd32768))
		else $error("squared error out of range");

endmodule

bind mlp_sgd_train_and_infer mlp_checker u_mlp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.result        (result)
);

[sim/tb_top.sv]
// Testbench for the 8-12-1 sigmoid perceptron with weight store and SGD step.
// Depends on rtl/mlp_pkg.sv and rtl/mlp_sgd_train_and_infer.sv; self-checking
// against a predictor of the network held here.
`timescale 1ns / 100ps

module tb_top;
	import mlp_pkg::*;

	localparam int N_IN     = 8;
	localparam int N_HID    = 12;
	localparam int ROM_SIZE = 256;
	localparam int BASE_BH  = N_IN * N_HID;
	localparam int BASE_WHO = BASE_BH + N_HID;
	localparam int BASE_BO  = BASE_WHO + N_HID;
	localparam int N_WEIGHTS = BASE_BO + 1;
	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int SETTLE    = 60;
	localparam int MAX_CYCLES = 400000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    result_strobe;
	result_t result;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic [15:0] cfg_data = '0;

	mlp_sgd_train_and_infer u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.result_strobe(result_strobe), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Network state as the predictor sees it
	longint  wts [N_WEIGHTS];
	longint  act_h [N_HID];
	longint  step_size;
	logic [15:0] sig_tab [ROM_SIZE];

	item_t   pending_items [$];
	result_t expected_results [$];
	int      errors = 0;
	bit      no_gaps = 1'b0;

	// Queue helpers
	function automatic void queue_item(input item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void expect_result(input result_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	// Sigmoid of a non-negative Q.16 value by series and repeated squaring
	function automatic logic [15:0] sig_positive(input longint unsigned xq);
		longint unsigned y, term, t, d;
		longint s;
		y = xq << 11;
		term = 64'd1 << 31;
		s = longint'(term);
		for (int n = 1; n <= 12; n++) begin
			term = ((term * y) >> 31) / longint'(n);
			if (n % 2 == 1) s = s - longint'(term);
			else s = s + longint'(term);
		end
		t = (s > 0) ? longint'(s) : 64'd0;
		for (int k = 0; k < 4; k++) t = (t * t) >> 31;
		d = (64'd1 << 31) + t;
		return 16'(((64'd1 << 46) + (d >> 1)) / d);
	endfunction

	function automatic longint sig_of(input longint x);
		longint ix;
		if (x > 32767) x = 32767;
		if (x < -32768) x = -32768;
		ix = ((x + 32768) * ROM_SIZE) >>> 16;
		if (ix >= ROM_SIZE) ix = ROM_SIZE - 1;
		return longint'(sig_tab[ix]);
	endfunction

	function automatic longint deriv(input longint a);
		return (a * (32768 - a)) >>> 15;
	endfunction

	function automatic longint rnd_shift(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Forward pass, optional SGD step; returns the expected answer
	function automatic result_t classify_and_learn(input item_t it);
		result_t r;
		longint  f [N_IN];
		longint  dh [N_HID];
		longint  acc, score, cls, err, d_o, lbl, t;
		r = '0;
		if (it.action == ACT_LOAD) begin
			if (it.weight_index < N_WEIGHTS)
				wts[it.weight_index] = longint'(it.weight_value);
			return r;
		end
		f = '{longint'(it.feature_a), longint'(it.feature_b), longint'(it.feature_c),
			longint'(it.feature_d), longint'(it.feature_e), longint'(it.feature_f),
			longint'(it.feature_g), longint'(it.feature_h)};
		for (int i = 0; i < N_HID; i++) begin
			acc = 0;
			for (int j = 0; j < N_IN; j++) acc += f[j] * wts[j * N_HID + i];
			act_h[i] = sig_of((acc >>> 15) + wts[BASE_BH + i]);
		end
		acc = 0;
		for (int i = 0; i < N_HID; i++) acc += act_h[i] * wts[BASE_WHO + i];
		score = sig_of((acc >>> 15) + wts[BASE_BO]);
		cls = (score > 16384) ? 1 : 0;
		r.predicted_class = cls[0];
		r.output_score = score[15:0];
		if (it.action != ACT_TRAIN) return r;
		lbl = longint'(it.true_label);
		err = lbl * 32768 - score;
		t = (err * err) >>> 15;
		r.squared_error = t[15:0];
		d_o = (lbl - cls) * deriv(score);
		for (int i = 0; i < N_HID; i++) begin
			t = (d_o * wts[BASE_WHO + i]) >>> 12;
			dh[i] = (t * deriv(act_h[i])) >>> 15;
		end
		wts[BASE_BO] = clip16(wts[BASE_BO] + rnd_shift(step_size * d_o, 19));
		for (int i = 0; i < N_HID; i++)
			wts[BASE_WHO + i] = clip16(wts[BASE_WHO + i] +
				rnd_shift(step_size * d_o * act_h[i], 34));
		for (int i = 0; i < N_HID; i++) begin
			wts[BASE_BH + i] = clip16(wts[BASE_BH + i] + rnd_shift(step_size * dh[i], 19));
			for (int j = 0; j < N_IN; j++)
				wts[j * N_HID + i] = clip16(wts[j * N_HID + i] +
					rnd_shift(step_size * dh[i] * f[j], 34));
		end
		return r;
	endfunction

	// Driver: one transfer per accepted start, next item from the queue
	always @(posedge clk) begin : drive_items
		logic  go;
		item_t nxt;
		go = start;
		nxt = item;
		if (arst_n && start && !busy) begin
			expect_result(classify_and_learn(item));
			go = 1'b0;
		end
		if (arst_n && !go && pending_items.size() > 0 &&
				(no_gaps || $urandom_range(99) >= 28)) begin
			nxt = pending_items.pop_front();
			go = 1'b1;
		end
		start <= go;
		item <= nxt;
	end

	// Monitor: each strobed result against the oldest expectation
	always @(posedge clk) begin : check_results
		result_t exp_r;
		if (arst_n && result_strobe) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.predicted_class !== exp_r.predicted_class) begin
					$display("%0t: class exp %0d got %0d", $time,
						exp_r.predicted_class, result.predicted_class);
					errors++;
				end
				if (result.output_score !== exp_r.output_score) begin
					$display("%0t: score exp %0d got %0d", $time,
						exp_r.output_score, result.output_score);
					errors++;
				end
				if (result.squared_error !== exp_r.squared_error) begin
					$display("%0t: sq error exp %0d got %0d", $time,
						exp_r.squared_error, result.squared_error);
					errors++;
				end
			end
		end
	end

	// Watchdog
	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic logic [15:0] rand_feature(input int p);
		if (p == 0) return 16'd0;
		if (p == 1) return 16'd32768;
		if (p == 2) return 16'($urandom);
		return 16'($urandom_range(32768));
	endfunction

	function automatic item_t random_item();
		item_t it;
		int    p;
		it = '0;
		p = $urandom_range(99);
		it.action = (p < 20) ? ACT_LOAD : (p < 60) ? ACT_TRAIN :
			(p < 95) ? ACT_CLASSIFY : ACT_SPARE;
		it.weight_index = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 121))
			: 7'($urandom_range(120));
		it.weight_value = ($urandom_range(1) == 0) ? 16'($urandom_range(4095) - 2048)
			: 16'($urandom);
		for (int k = 0; k < N_IN; k++) begin
			p = $urandom_range(9);
			case (k)
				0: it.feature_a = rand_feature(p);
				1: it.feature_b = rand_feature(p);
				2: it.feature_c = rand_feature(p);
				3: it.feature_d = rand_feature(p);
				4: it.feature_e = rand_feature(p);
				5: it.feature_f = rand_feature(p);
				6: it.feature_g = rand_feature(p);
				default: it.feature_h = rand_feature(p);
			endcase
		end
		it.true_label = 1'($urandom);
		return it;
	endfunction

	function automatic item_t make_item(input logic [1:0] a, input int ix, input int v,
			input logic [15:0] f, input logic lbl);
		item_t it;
		it = '0;
		it.action = a;
		it.weight_index = 7'(ix);
		it.weight_value = 16'(v);
		{it.feature_a, it.feature_b, it.feature_c, it.feature_d} = {4{f}};
		{it.feature_e, it.feature_f, it.feature_g, it.feature_h} = {4{~f}};
		it.true_label = lbl;
		return it;
	endfunction

	// Let the block drain and settle before the next phase
	task automatic wait_quiet();
		while (pending_items.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_rate(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		step_size = longint'(v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int n);
		for (int k = 0; k < n; k++) queue_item(random_item());
		wait_quiet();
	endtask

	initial begin
		for (int k = 0; k < ROM_SIZE; k++) begin : rom_fill
			longint m;
			m = -64'sd524288 + (longint'(2 * k + 1) * 64'sd524288) / ROM_SIZE;
			if (m >= 0) sig_tab[k] = sig_positive(m);
			else sig_tab[k] = 16'd32768 - sig_positive(-m);
		end
		foreach (wts[k]) wts[k] = 0;
		foreach (act_h[k]) act_h[k] = 0;
		step_size = 655;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: zero network, load extremes, out-of-range loads, spare code
		queue_item(make_item(ACT_CLASSIFY, 0, 0, 16'd0, 1'b0));
		queue_item(make_item(ACT_TRAIN, 0, 0, 16'd32768, 1'b1));
		queue_item(make_item(ACT_TRAIN, 0, 0, 16'd0, 1'b0));
		queue_item(make_item(ACT_LOAD, 0, 32767, 16'hffff, 1'b1));
		queue_item(make_item(ACT_LOAD, 120, -32768, 16'd0, 1'b0));
		queue_item(make_item(ACT_LOAD, BASE_WHO, 32767, 16'd0, 1'b0));
		queue_item(make_item(ACT_LOAD, BASE_BH, -32768, 16'd0, 1'b0));
		queue_item(make_item(ACT_LOAD, 121, 1234, 16'd0, 1'b0));
		queue_item(make_item(ACT_LOAD, 127, -1, 16'd0, 1'b1));
		queue_item(make_item(ACT_CLASSIFY, 0, 0, 16'd32768, 1'b0));
		queue_item(make_item(ACT_SPARE, 0, 0, 16'hffff, 1'b1));
		queue_item(make_item(ACT_TRAIN, 0, 0, 16'hffff, 1'b1));
		queue_item(make_item(ACT_TRAIN, 0, 0, 16'd32768, 1'b0));
		queue_item(make_item(ACT_TRAIN, 0, 0, 16'h5555, 1'b1));
		queue_item(make_item(ACT_LOAD, BASE_BO, 32767, 16'd0, 1'b0));
		queue_item(make_item(ACT_TRAIN, 0, 0, 16'd0, 1'b0));
		queue_item(make_item(ACT_TRAIN, 0, 0, 16'd0, 1'b1));
		wait_quiet();

		// Fill the whole store with small weights, then mixed traffic
		for (int k = 0; k < N_WEIGHTS; k++)
			queue_item(make_item(ACT_LOAD, k,
				int'($urandom_range(4095)) - 2048, 16'd0, 1'b0));
		random_phase(80);

		write_rate(16'hffff);
		no_gaps = 1'b1;
		random_phase(80);
		no_gaps = 1'b0;

		write_rate(16'd0);
		random_phase(70);
		write_rate(16'd1);
		random_phase(70);
		write_rate(16'($urandom));
		random_phase(70);
		write_rate(16'd655);
		random_phase(40);

		if (errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

[files.f]
rtl/mlp_pkg.sv
rtl/mlp_lane.sv
rtl/mlp_merge.sv
rtl/mlp_sgd_train_and_infer.sv
rtl/mlp_checker.sv
sim/tb_top.sv
